// ===== rtl/fwsrs_pkg.sv =====
// package for the fixed width string row sorter
// holds default sizes, sequencer states and the cell control struct; no dependencies
`default_nettype none
package fwsrs_pkg;

  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESTART,
    ST_LOAD,
    ST_RD,
    ST_RD_OUT,
    ST_S_NEXT,
    ST_S_SETUP,
    ST_S_ISSUE,
    ST_S_CMP,
    ST_S_PLACE
  } state_t;

  typedef struct packed {
    logic init;
    logic ld_left;
    logic ld_cur;
    logic ld_len;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/fwsrs_cell.sv =====
// one rank cell of the sort chain: holds a row id and its length
// uses fwsrs_pkg for the control struct
`default_nettype none
module fwsrs_cell #(
  parameter int RW  = 5,
  parameter int LW  = 6,
  parameter int IDX = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fwsrs_pkg::cell_ctrl_t  ctrl,
  input  wire logic [RW-1:0]          left_id,
  input  wire logic [LW-1:0]          left_len,
  input  wire logic [RW-1:0]          cur_id,
  input  wire logic [LW-1:0]          cur_len,
  input  wire logic [LW-1:0]          wr_len,
  output logic      [RW-1:0]          id,
  output logic      [LW-1:0]          len
);
  import fwsrs_pkg::*;

  logic [RW-1:0] id_r, id_nxt;
  logic [LW-1:0] len_r, len_nxt;

  always_comb begin
    id_nxt  = id_r;
    len_nxt = len_r;
    if (ctrl.init) begin
      id_nxt  = RW'(IDX);
      len_nxt = '0;
    end else if (ctrl.ld_left) begin
      // take the neighbour's entry as it moves up one rank
      id_nxt  = left_id;
      len_nxt = left_len;
    end else if (ctrl.ld_cur) begin
      id_nxt  = cur_id;
      len_nxt = cur_len;
    end else if (ctrl.ld_len) begin
      len_nxt = wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r  <= RW'(IDX);
      len_r <= '0;
    end else begin
      id_r  <= id_nxt;
      len_r <= len_nxt;
    end
  end

  assign id  = id_r;
  assign len = len_r;

endmodule
`default_nettype wire

// ===== rtl/fwsrs_mem.sv =====
// character store: one write port, two registered read ports
// no package dependency
`default_nettype none
module fwsrs_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [7:0]    rdata_a,
  output logic      [7:0]    rdata_b
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== rtl/fixed_width_string_row_sorter.sv =====
// top level of the fixed width string row sorter: sequencer, counters, cell chain
// depends on fwsrs_pkg, fwsrs_cell and fwsrs_mem
//
//   channel | ports                                   | handshake
//   input   | in_req_type in_char_in in_end_of_row    | start high, busy low
//           | in_end_of_set in_read_rank in_read_col  |
//   result  | out_char_out out_row_count              | out_valid one cycle
//           | out_longest_len out_truncated           |
//
// a load item goes through the load state, after a restart when it opens a new set;
// a read item goes through the read and read-out states, which registers its result
// end of set runs an insertion sort over the cell chain: each string compare reads
// both rows from the character store's two ports, and the sort is about
// rows*rows/2 compares in the worst case
// reset is synchronous; the result side cannot stall, busy holds off the input side
`default_nettype none
module fixed_width_string_row_sorter #(
  parameter int ROWS = fwsrs_pkg::ROWS_DEF,
  parameter int COLS = fwsrs_pkg::COLS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_row,
  input  wire logic       in_end_of_set,
  input  wire logic [4:0] in_read_rank,
  input  wire logic [4:0] in_read_col,
  output logic            out_valid,
  output logic [7:0]      out_char_out,
  output logic [5:0]      out_row_count,
  output logic [5:0]      out_longest_len,
  output logic            out_truncated
);
  import fwsrs_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int NW = $clog2(ROWS + 1);
  localparam int LW = $clog2(COLS + 1);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW = $clog2(DEPTH);

  state_t state_r, state_nxt;

  logic       req_r, eor_r, eos_r;
  logic [7:0] ch_r;
  logic [4:0] rank_r, col_rd_r;

  logic [NW-1:0] total_r, total_nxt;
  logic [LW-1:0] colp_r, colp_nxt;
  logic [LW-1:0] maxl_r, maxl_nxt;
  logic          ovf_r, ovf_nxt;
  logic          done_r, done_nxt;

  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [RW-1:0] cur_id_r, cur_id_nxt, prev_id_r, prev_id_nxt;
  logic [LW-1:0] cur_len_r, cur_len_nxt, prev_len_r, prev_len_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;

  logic [RW-1:0] cell_id  [ROWS];
  logic [LW-1:0] cell_len [ROWS];
  cell_ctrl_t    ctrl     [ROWS];

  logic [RW-1:0] sel_idx;
  logic [RW-1:0] sel_id;
  logic [LW-1:0] sel_len;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, raddr_a, raddr_b;
  logic [7:0]    rdata_a, rdata_b;

  logic [LW-1:0] cmp_n;
  logic          accept;
  logic          shift_now, place_now;
  logic [NW-1:0] place_j;
  logic [6:0]    rank_w;
  logic          row_room, col_room;
  logic [LW-1:0] col_after;

  assign accept   = start && !busy;
  assign rank_w   = 7'(rank_r);
  assign row_room = total_r < NW'(ROWS);
  assign col_room = colp_r < LW'(COLS);
  assign col_after = (row_room && col_room) ? colp_r + LW'(1) : colp_r;
  assign cmp_n    = (cur_len_r < prev_len_r) ? cur_len_r : prev_len_r;

  // single read address into the chain
  always_comb begin
    unique case (state_r)
      ST_RD:      sel_idx = rank_w[RW-1:0];
      ST_S_NEXT:  sel_idx = i_r[RW-1:0];
      default:    sel_idx = RW'(j_r - NW'(1));
    endcase
  end
  assign sel_id  = cell_id[sel_idx];
  assign sel_len = cell_len[sel_idx];

  for (genvar g = 0; g < ROWS; g++) begin : g_cell
    logic [RW-1:0] lid;
    logic [LW-1:0] llen;
    if (g == 0) begin : g_first
      assign lid  = '0;
      assign llen = '0;
    end else begin : g_rest
      assign lid  = cell_id[g-1];
      assign llen = cell_len[g-1];
    end
    assign ctrl[g].init    = (state_r == ST_RESTART);
    assign ctrl[g].ld_left = shift_now && (j_r == NW'(g));
    assign ctrl[g].ld_cur  = place_now && (place_j == NW'(g));
    assign ctrl[g].ld_len  = (state_r == ST_LOAD) && (eor_r || eos_r) && row_room
                             && (total_r == NW'(g));
    fwsrs_cell #(.RW(RW), .LW(LW), .IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[g]),
      .left_id  (lid),
      .left_len (llen),
      .cur_id   (cur_id_r),
      .cur_len  (cur_len_r),
      .wr_len   (col_after),
      .id       (cell_id[g]),
      .len      (cell_len[g])
    );
  end

  assign mem_we    = (state_r == ST_LOAD) && row_room && col_room;
  assign mem_waddr = AW'(int'(total_r) * COLS + int'(colp_r));
  assign raddr_a   = (state_r == ST_RD) ? AW'(int'(sel_id) * COLS + int'(col_rd_r))
                                        : AW'(int'(cur_id_r) * COLS + int'(k_r));
  assign raddr_b   = AW'(int'(prev_id_r) * COLS + int'(k_r));

  fwsrs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (ch_r),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // compare outcome for the sort: before means cur sorts ahead of prev
  logic cmp_end, cmp_before;
  always_comb begin
    cmp_end    = 1'b0;
    cmp_before = 1'b0;
    if (state_r == ST_S_ISSUE && k_r == cmp_n) begin
      cmp_end    = 1'b1;
      cmp_before = cur_len_r < prev_len_r;
    end else if (state_r == ST_S_CMP && rdata_a != rdata_b) begin
      cmp_end    = 1'b1;
      cmp_before = rdata_a < rdata_b;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type) state_nxt = ST_RD;
          else if (done_r) state_nxt = ST_RESTART;
          else state_nxt = ST_LOAD;
        end
      end
      ST_RESTART: state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = eos_r ? ST_S_NEXT : ST_IDLE;
      ST_RD:      state_nxt = ST_RD_OUT;
      ST_RD_OUT:  state_nxt = ST_IDLE;
      ST_S_NEXT:  state_nxt = (i_r >= total_r) ? ST_IDLE : ST_S_SETUP;
      ST_S_SETUP: state_nxt = ST_S_ISSUE;
      ST_S_ISSUE: begin
        if (cmp_end) state_nxt = (cmp_before && j_r != NW'(1)) ? ST_S_SETUP : ST_S_PLACE;
        else state_nxt = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (cmp_end) state_nxt = (cmp_before && j_r != NW'(1)) ? ST_S_SETUP : ST_S_PLACE;
        else state_nxt = ST_S_ISSUE;
      end
      ST_S_PLACE: state_nxt = ST_S_NEXT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    total_nxt     = total_r;
    colp_nxt      = colp_r;
    maxl_nxt      = maxl_r;
    ovf_nxt       = ovf_r;
    done_nxt      = done_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_id_nxt    = cur_id_r;
    cur_len_nxt   = cur_len_r;
    prev_id_nxt   = prev_id_r;
    prev_len_nxt  = prev_len_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    shift_now     = 1'b0;
    place_now     = 1'b0;
    place_j       = j_r;
    unique case (state_r)
      ST_RESTART: begin
        total_nxt = '0;
        colp_nxt  = '0;
        maxl_nxt  = '0;
        ovf_nxt   = 1'b0;
        done_nxt  = 1'b0;
      end
      ST_LOAD: begin
        colp_nxt = col_after;
        if (!(row_room && col_room)) ovf_nxt = 1'b1;
        if (eor_r || eos_r) begin
          if (row_room) begin
            if (col_after > maxl_r) maxl_nxt = col_after;
            total_nxt = total_r + NW'(1);
          end
          colp_nxt = '0;
        end
        if (eos_r) begin
          done_nxt = 1'b1;
          i_nxt    = NW'(1);
        end
      end
      ST_RD: begin
        rd_ok_nxt = (rank_w < 7'(total_r)) && (8'(col_rd_r) < 8'(sel_len));
      end
      ST_RD_OUT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rd_ok_r ? rdata_a : 8'd0;
      end
      ST_S_NEXT: begin
        cur_id_nxt  = sel_id;
        cur_len_nxt = sel_len;
        j_nxt       = i_r;
      end
      ST_S_SETUP: begin
        prev_id_nxt  = sel_id;
        prev_len_nxt = sel_len;
        k_nxt        = '0;
      end
      ST_S_ISSUE, ST_S_CMP: begin
        if (cmp_end) begin
          if (cmp_before) begin
            shift_now = 1'b1;
            j_nxt     = j_r - NW'(1);
          end
        end else if (state_r == ST_S_CMP) begin
          k_nxt = k_r + LW'(1);
        end
      end
      ST_S_PLACE: begin
        place_now = 1'b1;
        i_nxt     = i_r + NW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      colp_r      <= '0;
      maxl_r      <= '0;
      ovf_r       <= 1'b0;
      done_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      colp_r      <= colp_nxt;
      maxl_r      <= maxl_nxt;
      ovf_r       <= ovf_nxt;
      done_r      <= done_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req_type;
      ch_r     <= in_char_in;
      eor_r    <= in_end_of_row;
      eos_r    <= in_end_of_set;
      rank_r   <= in_read_rank;
      col_rd_r <= in_read_col;
    end
    cur_id_r   <= cur_id_nxt;
    cur_len_r  <= cur_len_nxt;
    prev_id_r  <= prev_id_nxt;
    prev_len_r <= prev_len_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_char_r <= out_char_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_row_count   = 6'(total_r);
  assign out_longest_len = 6'(maxl_r);
  assign out_truncated   = ovf_r;

  a_strobe_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_RD_OUT))
    else $error("result strobe without a read");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= NW'(ROWS))
    else $error("row count beyond capacity");
  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S_ISSUE || state_r == ST_S_CMP) |-> (j_r >= NW'(1) && j_r <= i_r))
    else $error("insertion index out of range");
  a_read_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> req_r)
    else $error("read state for a load item");

endmodule
`default_nettype wire
